@@ hw/rtl/frff_pkg.sv @@
// Package for the generator field regulator with fault detection.
// Holds the mode, fault cause, action and register codes shared by the RTL.
// Depends on nothing.
package frff_pkg;

    localparam int VOLT_W  = 16;
    localparam int AMP_W   = 16;
    localparam int TEMP_W  = 9;
    localparam int PWR_W   = 32;
    localparam int ACT_W   = 3;
    localparam int MODE_W  = 2;
    localparam int CAUSE_W = 2;
    localparam int CNT_OUT_W = 32;
    localparam int APB_AW  = 4;
    localparam int APB_DW  = 32;

    typedef logic [MODE_W-1:0]  mode_t;
    typedef logic [CAUSE_W-1:0] cause_t;
    typedef logic [ACT_W-1:0]   action_t;

    localparam mode_t MODE_RUN    = 2'd0;
    localparam mode_t MODE_IDLE   = 2'd1;
    localparam mode_t MODE_FAILED = 2'd2;
    localparam mode_t MODE_SLEEP  = 2'd3;

    localparam cause_t CAUSE_NONE  = 2'd0;
    localparam cause_t CAUSE_SHORT = 2'd1;
    localparam cause_t CAUSE_OPEN  = 2'd2;
    localparam cause_t CAUSE_HOT   = 2'd3;

    localparam action_t ACT_SAMPLE = 3'd0;
    localparam action_t ACT_START  = 3'd1;
    localparam action_t ACT_STOP   = 3'd2;
    localparam action_t ACT_SLEEP  = 3'd3;
    localparam action_t ACT_WAKE   = 3'd4;

    localparam logic [1:0] REG_VOLT_LIMIT  = 2'd0;
    localparam logic [1:0] REG_CURR_LIMIT  = 2'd1;
    localparam logic [1:0] REG_POWER_LIMIT = 2'd2;

    localparam logic [VOLT_W-1:0] VOLT_LIMIT_RST  = 16'd14400;
    localparam logic [AMP_W-1:0]  CURR_LIMIT_RST  = 16'd10000;
    localparam logic [PWR_W-1:0]  POWER_LIMIT_RST = 32'd144000000;

    localparam logic signed [TEMP_W-1:0] TEMP_HOT_LIMIT = 9'sd125;

endpackage

@@ hw/rtl/field_regulator_fault_fsm.sv @@
// Generator field regulator: mode sequencer, fault checks and period counters.
// Path: input register, then the mode and counter registers, which form the result register.
// Throughput: one transaction per cycle while the output is not stalled.
// Reset: mode run, field off, power rail on, no fault, counters zero, limits at defaults.
// Depends on frff_pkg.
module field_regulator_fault_fsm #(
    parameter int COUNTER_BITS = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [frff_pkg::APB_AW-1:0]     paddr,
    input  logic [frff_pkg::APB_DW-1:0]     pwdata,
    output logic [frff_pkg::APB_DW-1:0]     prdata,
    output logic                            pready,

    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [frff_pkg::ACT_W-1:0]      action,
    input  logic [frff_pkg::VOLT_W-1:0]     bus_volts_mv,
    input  logic [frff_pkg::AMP_W-1:0]      bus_amps_ma,
    input  logic [frff_pkg::AMP_W-1:0]      avg_amps_ma,
    input  logic signed [frff_pkg::TEMP_W-1:0] die_temp_c,

    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            field_enable,
    output logic                            power_enable,
    output logic [frff_pkg::MODE_W-1:0]     mode,
    output logic [frff_pkg::CAUSE_W-1:0]    fault_cause,
    output logic [frff_pkg::CNT_OUT_W-1:0]  on_periods,
    output logic [frff_pkg::CNT_OUT_W-1:0]  off_periods
);

    logic [frff_pkg::VOLT_W-1:0] vlim_reg;
    logic [frff_pkg::AMP_W-1:0]  clim_reg;
    logic [frff_pkg::PWR_W-1:0]  plim_reg;
    logic                        cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vlim_reg <= frff_pkg::VOLT_LIMIT_RST;
            clim_reg <= frff_pkg::CURR_LIMIT_RST;
            plim_reg <= frff_pkg::POWER_LIMIT_RST;
        end
        else if (cfg_write)
        begin
            unique case (paddr[3:2])
                frff_pkg::REG_VOLT_LIMIT:  vlim_reg <= pwdata[frff_pkg::VOLT_W-1:0];
                frff_pkg::REG_CURR_LIMIT:  clim_reg <= pwdata[frff_pkg::AMP_W-1:0];
                frff_pkg::REG_POWER_LIMIT: plim_reg <= pwdata[frff_pkg::PWR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            frff_pkg::REG_VOLT_LIMIT:  prdata = {16'd0, vlim_reg};
            frff_pkg::REG_CURR_LIMIT:  prdata = {16'd0, clim_reg};
            frff_pkg::REG_POWER_LIMIT: prdata = plim_reg;
            default:                   prdata = '0;
        endcase
    end

    // Input register stage.
    logic                                s1_valid_reg;
    frff_pkg::action_t                   s1_act_reg;
    logic [frff_pkg::VOLT_W-1:0]         s1_volts_reg;
    logic [frff_pkg::AMP_W-1:0]          s1_amps_reg;
    logic [frff_pkg::AMP_W-1:0]          s1_avg_reg;
    logic signed [frff_pkg::TEMP_W-1:0]  s1_temp_reg;
    logic                                advance;
    logic                                in_take;

    logic                                out_valid_reg;

    assign advance  = !out_valid_reg || !out_stall;
    assign in_stall = s1_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (advance || !s1_valid_reg)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_act_reg   <= action;
            s1_volts_reg <= bus_volts_mv;
            s1_amps_reg  <= bus_amps_ma;
            s1_avg_reg   <= avg_amps_ma;
            s1_temp_reg  <= die_temp_c;
        end
    end

    // Mode and counter state; these registers also hold the result.
    frff_pkg::mode_t         mode_reg, mode_next;
    logic                    field_reg, field_next;
    logic                    power_reg, power_next;
    frff_pkg::cause_t        fault_reg, fault_next;
    logic [COUNTER_BITS-1:0] on_cnt_reg, on_cnt_next;
    logic [COUNTER_BITS-1:0] off_cnt_reg, off_cnt_next;

    logic [19:0] avg_x10;
    logic [19:0] clim_x11;
    logic [19:0] volts_x10;
    logic [19:0] vlim_x11;
    logic [31:0] power_mw;
    logic        is_short;
    logic        is_open;
    logic        is_hot;
    logic        field_ok;

    assign avg_x10   = 20'(s1_avg_reg) * 20'd10;
    assign clim_x11  = 20'(clim_reg) * 20'd11;
    assign volts_x10 = 20'(s1_volts_reg) * 20'd10;
    assign vlim_x11  = 20'(vlim_reg) * 20'd11;
    assign power_mw  = 32'(s1_volts_reg) * 32'(s1_amps_reg);

    assign is_short = (avg_x10 > clim_x11) && (volts_x10 < 20'(vlim_reg));
    assign is_open  = (volts_x10 > vlim_x11) && (avg_x10 < 20'(clim_reg));
    assign is_hot   = s1_temp_reg > frff_pkg::TEMP_HOT_LIMIT;
    assign field_ok = !(power_mw > plim_reg) && !(s1_amps_reg > clim_reg)
                      && !(s1_volts_reg > vlim_reg);

    always_comb
    begin
        mode_next    = mode_reg;
        field_next   = field_reg;
        power_next   = power_reg;
        fault_next   = fault_reg;
        on_cnt_next  = on_cnt_reg;
        off_cnt_next = off_cnt_reg;
        unique case (mode_reg)
            frff_pkg::MODE_RUN:
            begin
                if (s1_act_reg == frff_pkg::ACT_SAMPLE)
                begin
                    if (is_short || is_open || is_hot)
                    begin
                        mode_next  = frff_pkg::MODE_FAILED;
                        field_next = 1'b0;
                        if (is_short)
                            fault_next = frff_pkg::CAUSE_SHORT;
                        else if (is_open)
                            fault_next = frff_pkg::CAUSE_OPEN;
                        else
                            fault_next = frff_pkg::CAUSE_HOT;
                    end
                    else
                    begin
                        field_next = field_ok;
                        if (field_ok)
                        begin
                            if (on_cnt_reg != '1)
                                on_cnt_next = on_cnt_reg + 1'b1;
                        end
                        else if (off_cnt_reg != '1)
                        begin
                            off_cnt_next = off_cnt_reg + 1'b1;
                        end
                    end
                end
                else if (s1_act_reg == frff_pkg::ACT_STOP)
                begin
                    mode_next  = frff_pkg::MODE_IDLE;
                    field_next = 1'b0;
                end
                else if (s1_act_reg == frff_pkg::ACT_SLEEP)
                begin
                    mode_next  = frff_pkg::MODE_SLEEP;
                    power_next = 1'b0;
                    field_next = 1'b1;
                end
            end
            frff_pkg::MODE_IDLE:
            begin
                if (s1_act_reg == frff_pkg::ACT_START)
                begin
                    mode_next  = frff_pkg::MODE_RUN;
                    power_next = 1'b1;
                end
                else if (s1_act_reg == frff_pkg::ACT_SLEEP)
                begin
                    mode_next  = frff_pkg::MODE_SLEEP;
                    power_next = 1'b0;
                    field_next = 1'b1;
                end
            end
            frff_pkg::MODE_FAILED:
            begin
                if (s1_act_reg == frff_pkg::ACT_SLEEP)
                begin
                    mode_next  = frff_pkg::MODE_SLEEP;
                    power_next = 1'b0;
                    field_next = 1'b1;
                    fault_next = frff_pkg::CAUSE_NONE;
                end
            end
            frff_pkg::MODE_SLEEP:
            begin
                if (s1_act_reg == frff_pkg::ACT_WAKE)
                begin
                    mode_next  = frff_pkg::MODE_RUN;
                    power_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            mode_reg      <= frff_pkg::MODE_RUN;
            field_reg     <= 1'b0;
            power_reg     <= 1'b1;
            fault_reg     <= frff_pkg::CAUSE_NONE;
            on_cnt_reg    <= '0;
            off_cnt_reg   <= '0;
        end
        else if (advance)
        begin
            out_valid_reg <= s1_valid_reg;
            if (s1_valid_reg)
            begin
                mode_reg    <= mode_next;
                field_reg   <= field_next;
                power_reg   <= power_next;
                fault_reg   <= fault_next;
                on_cnt_reg  <= on_cnt_next;
                off_cnt_reg <= off_cnt_next;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign field_enable = field_reg;
    assign power_enable = power_reg;
    assign mode         = mode_reg;
    assign fault_cause  = fault_reg;

    generate
        if (COUNTER_BITS >= frff_pkg::CNT_OUT_W)
        begin : g_cnt_trunc
            assign on_periods  = on_cnt_reg[frff_pkg::CNT_OUT_W-1:0];
            assign off_periods = off_cnt_reg[frff_pkg::CNT_OUT_W-1:0];
        end
        else
        begin : g_cnt_ext
            assign on_periods  = {{(frff_pkg::CNT_OUT_W-COUNTER_BITS){1'b0}}, on_cnt_reg};
            assign off_periods = {{(frff_pkg::CNT_OUT_W-COUNTER_BITS){1'b0}}, off_cnt_reg};
        end
    endgenerate

    // A latched fault cause goes together with the failed mode and nothing else.
    assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == frff_pkg::MODE_FAILED) == (fault_reg != frff_pkg::CAUSE_NONE))
        else $error("fault cause out of step with failed mode");

    // The field is never driven while failed or idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == frff_pkg::MODE_FAILED || mode_reg == frff_pkg::MODE_IDLE) |-> !field_reg)
        else $error("field driven in failed or idle mode");

    // The power rail is off exactly in sleep.
    assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == frff_pkg::MODE_SLEEP) == !power_reg)
        else $error("power rail out of step with sleep mode");

    // Counters only move on an accepted transaction and never go down.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(advance && s1_valid_reg) |=> $stable(on_cnt_reg) && $stable(off_cnt_reg))
        else $error("counter changed without a transaction");

    // At most one counter steps per transaction.
    assert property (@(posedge clk) disable iff (!rst_n)
        !((on_cnt_next != on_cnt_reg) && (off_cnt_next != off_cnt_reg)))
        else $error("both period counters stepped together");

endmodule

@@ tb/tb_field_regulator_fault_fsm.sv @@
// Self-checking testbench for the generator field regulator with fault detection.
// Drives random and directed transactions, predicts each result and compares field by field.
// Depends on frff_pkg and field_regulator_fault_fsm.
module tb_field_regulator_fault_fsm;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF    = 10;
    localparam int COUNT_W     = 32;
    localparam int TEMP_TRIP_C = 125;
    localparam int STUCK_LIMIT = 1000;
    localparam int PHASE_ITEMS = 230;
    localparam int LONG_HOLD   = 80;

    localparam logic [1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        frff_pkg::action_t           act;
        logic [frff_pkg::VOLT_W-1:0] volts;
        logic [frff_pkg::AMP_W-1:0]  amps;
        logic [frff_pkg::AMP_W-1:0]  avg;
        logic [frff_pkg::TEMP_W-1:0] temp;
    } sample_t;

    typedef struct packed {
        logic                           field;
        logic                           power;
        frff_pkg::mode_t                mode;
        frff_pkg::cause_t               cause;
        logic [frff_pkg::CNT_OUT_W-1:0] on_cnt;
        logic [frff_pkg::CNT_OUT_W-1:0] off_cnt;
    } status_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                        psel = 1'b0;
    logic                        penable = 1'b0;
    logic                        pwrite = 1'b0;
    logic [frff_pkg::APB_AW-1:0] paddr = '0;
    logic [frff_pkg::APB_DW-1:0] pwdata = '0;
    logic [frff_pkg::APB_DW-1:0] prdata;
    logic                        pready;

    logic                               in_valid = 1'b0;
    logic                               in_stall;
    logic [frff_pkg::ACT_W-1:0]         action = '0;
    logic [frff_pkg::VOLT_W-1:0]        bus_volts_mv = '0;
    logic [frff_pkg::AMP_W-1:0]         bus_amps_ma = '0;
    logic [frff_pkg::AMP_W-1:0]         avg_amps_ma = '0;
    logic signed [frff_pkg::TEMP_W-1:0] die_temp_c = '0;

    logic                           out_valid;
    logic                           out_stall = 1'b0;
    logic                           field_enable;
    logic                           power_enable;
    logic [frff_pkg::MODE_W-1:0]    mode;
    logic [frff_pkg::CAUSE_W-1:0]   fault_cause;
    logic [frff_pkg::CNT_OUT_W-1:0] on_periods;
    logic [frff_pkg::CNT_OUT_W-1:0] off_periods;

    logic [frff_pkg::VOLT_W-1:0] volt_lim = frff_pkg::VOLT_LIMIT_RST;
    logic [frff_pkg::AMP_W-1:0]  curr_lim = frff_pkg::CURR_LIMIT_RST;
    logic [frff_pkg::PWR_W-1:0]  pwr_lim = frff_pkg::POWER_LIMIT_RST;
    frff_pkg::mode_t             reg_mode = frff_pkg::MODE_RUN;
    logic                        reg_field = 1'b0;
    logic                        reg_power = 1'b1;
    frff_pkg::cause_t            reg_cause = frff_pkg::CAUSE_NONE;
    logic [COUNT_W-1:0]          on_count = '0;
    logic [COUNT_W-1:0]          off_count = '0;

    sample_t sample_q[$];
    status_t pending_status[$];

    bit in_fire = 1'b0;
    bit out_fire = 1'b0;
    bit tx_quiet = 1'b0;
    bit rx_quiet = 1'b0;
    int tx_gap = 0;
    int rx_wait = 0;
    int results_seen = 0;
    int mismatches = 0;
    int stuck = 0;

    field_regulator_fault_fsm u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .action       (action),
        .bus_volts_mv (bus_volts_mv),
        .bus_amps_ma  (bus_amps_ma),
        .avg_amps_ma  (avg_amps_ma),
        .die_temp_c   (die_temp_c),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .field_enable (field_enable),
        .power_enable (power_enable),
        .mode         (mode),
        .fault_cause  (fault_cause),
        .on_periods   (on_periods),
        .off_periods  (off_periods)
    );

    always #(CLK_HALF) clk = !clk;

    function automatic void enter_mode(frff_pkg::mode_t next);
        if (reg_mode == frff_pkg::MODE_RUN)
            reg_field = 1'b0;
        if (reg_mode == frff_pkg::MODE_SLEEP)
            reg_power = 1'b1;
        if (reg_mode == frff_pkg::MODE_FAILED && next != frff_pkg::MODE_FAILED)
            reg_cause = frff_pkg::CAUSE_NONE;
        reg_mode = next;
        case (next)
            frff_pkg::MODE_RUN:
                reg_power = 1'b1;
            frff_pkg::MODE_IDLE, frff_pkg::MODE_FAILED:
                reg_field = 1'b0;
            default:
            begin
                reg_power = 1'b0;
                reg_field = 1'b1;
            end
        endcase
    endfunction

    function automatic status_t regulate_step(sample_t s);
        longint unsigned  v;
        longint unsigned  a;
        longint unsigned  avg;
        longint unsigned  vl;
        longint unsigned  cl;
        int               t;
        frff_pkg::cause_t hit;
        logic             en;
        v   = s.volts;
        a   = s.amps;
        avg = s.avg;
        vl  = volt_lim;
        cl  = curr_lim;
        t   = $signed(s.temp);
        case (reg_mode)
            frff_pkg::MODE_RUN:
            begin
                if (s.act == frff_pkg::ACT_SAMPLE)
                begin
                    hit = frff_pkg::CAUSE_NONE;
                    if (10 * avg > 11 * cl && 10 * v < vl)
                        hit = frff_pkg::CAUSE_SHORT;
                    else if (10 * v > 11 * vl && 10 * avg < cl)
                        hit = frff_pkg::CAUSE_OPEN;
                    else if (t > TEMP_TRIP_C)
                        hit = frff_pkg::CAUSE_HOT;
                    if (hit != frff_pkg::CAUSE_NONE)
                    begin
                        enter_mode(frff_pkg::MODE_FAILED);
                        reg_cause = hit;
                    end
                    else
                    begin
                        en = !(v * a > pwr_lim || a > cl || v > vl);
                        reg_field = en;
                        if (en)
                        begin
                            if (on_count != '1)
                                on_count++;
                        end
                        else if (off_count != '1)
                            off_count++;
                    end
                end
                else if (s.act == frff_pkg::ACT_STOP)
                    enter_mode(frff_pkg::MODE_IDLE);
                else if (s.act == frff_pkg::ACT_SLEEP)
                    enter_mode(frff_pkg::MODE_SLEEP);
            end
            frff_pkg::MODE_IDLE:
            begin
                if (s.act == frff_pkg::ACT_START)
                    enter_mode(frff_pkg::MODE_RUN);
                else if (s.act == frff_pkg::ACT_SLEEP)
                    enter_mode(frff_pkg::MODE_SLEEP);
            end
            frff_pkg::MODE_FAILED:
            begin
                if (s.act == frff_pkg::ACT_SLEEP)
                    enter_mode(frff_pkg::MODE_SLEEP);
            end
            default:
            begin
                if (s.act == frff_pkg::ACT_WAKE)
                    enter_mode(frff_pkg::MODE_RUN);
            end
        endcase
        return {reg_field, reg_power, reg_mode, reg_cause,
                on_count[frff_pkg::CNT_OUT_W-1:0], off_count[frff_pkg::CNT_OUT_W-1:0]};
    endfunction

    function automatic sample_t pack_item(frff_pkg::action_t act, int volts = 0,
                                          int amps = 0, int avg = 0, int temp = 0);
        return {act, 16'(volts), 16'(amps), 16'(avg), 9'(temp)};
    endfunction

    function automatic logic [15:0] pick_near(int center);
        int val;
        val = center + int'($urandom_range(0, 16)) - 8;
        if (val < 0)
            val = 0;
        if (val > 65535)
            val = 65535;
        return 16'(val);
    endfunction

    function automatic logic [15:0] pick_level(int lim);
        case ($urandom_range(0, 5))
            0:       return pick_near(lim / 10);
            1:       return pick_near(lim * 11 / 10);
            2, 3:    return pick_near(lim);
            4:       return 16'($urandom_range(0, lim));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic sample_t rand_sample(frff_pkg::action_t act);
        sample_t s;
        s.act   = act;
        s.volts = pick_level(volt_lim);
        s.amps  = pick_level(curr_lim);
        s.avg   = pick_level(curr_lim);
        case ($urandom_range(0, 7))
            0:       s.temp = 9'($urandom_range(0, 511));
            1:       s.temp = 9'(120 + $urandom_range(0, 10));
            default: s.temp = 9'($urandom_range(0, 160)) - 9'd40;
        endcase
        return s;
    endfunction

    // Bursts of period samples, most followed by a mode sequence that moves the
    // regulator out of the failed or idle mode; others get stray actions or nothing.
    function automatic void queue_traffic(int count);
        int made;
        made = 0;
        while (made < count)
        begin
            repeat ($urandom_range(3, 14))
            begin
                sample_q.push_back(rand_sample(frff_pkg::ACT_SAMPLE));
                made++;
            end
            case ($urandom_range(0, 11))
                0, 1, 2, 3, 4:
                begin
                    sample_q.push_back(rand_sample(frff_pkg::ACT_SLEEP));
                    sample_q.push_back(rand_sample(frff_pkg::ACT_WAKE));
                end
                5:
                begin
                    sample_q.push_back(rand_sample(frff_pkg::ACT_STOP));
                    sample_q.push_back(rand_sample(
                        frff_pkg::action_t'($urandom_range(0, 7))));
                    sample_q.push_back(rand_sample(frff_pkg::ACT_START));
                end
                6:
                begin
                    sample_q.push_back(rand_sample(frff_pkg::ACT_STOP));
                    sample_q.push_back(rand_sample(frff_pkg::ACT_SLEEP));
                    sample_q.push_back(rand_sample(frff_pkg::ACT_WAKE));
                end
                7:
                    sample_q.push_back(rand_sample(
                        frff_pkg::action_t'($urandom_range(5, 7))));
                8:
                    sample_q.push_back(rand_sample(
                        frff_pkg::action_t'($urandom_range(1, 4))));
                default:
                    ;
            endcase
        end
    endfunction

    function automatic int draw_wait(bit quiet);
        return quiet ? 0 : int'($urandom_range(0, 5));
    endfunction

    task automatic wait_drained();
        while (sample_q.size() != 0 || in_valid || pending_status.size() != 0)
            @(posedge clk);
    endtask

    task automatic run_phase(int count);
        queue_traffic(count);
        wait_drained();
    endtask

    task automatic set_limit(logic [1:0] idx, logic [31:0] val);
        logic [31:0] kept;
        kept = (idx == frff_pkg::REG_POWER_LIMIT) ? val : {16'h0, val[15:0]};
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        case (idx)
            frff_pkg::REG_VOLT_LIMIT:  volt_lim = kept[frff_pkg::VOLT_W-1:0];
            frff_pkg::REG_CURR_LIMIT:  curr_lim = kept[frff_pkg::AMP_W-1:0];
            frff_pkg::REG_POWER_LIMIT: pwr_lim  = kept;
            default:                   ;
        endcase
        if (idx != REG_UNUSED)
        begin
            @(negedge clk);
            penable <= 1'b0;
            pwrite  <= 1'b0;
            @(negedge clk);
            penable <= 1'b1;
            do
                @(posedge clk);
            while (!pready);
            if (prdata !== kept)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("register %0d readback: expected %h, got %h", idx, kept, prdata);
            end
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_fire))
        begin
            if (in_fire)
            begin
                tx_gap = draw_wait(tx_quiet);
                if ($urandom_range(0, 49) == 0)
                    tx_quiet = !tx_quiet;
            end
            if (tx_gap > 0)
            begin
                tx_gap--;
                in_valid <= 1'b0;
            end
            else if (sample_q.size() != 0)
            begin
                {action, bus_volts_mv, bus_amps_ma, avg_amps_ma, die_temp_c}
                    <= sample_q.pop_front();
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // The receiver holds off twice for a long stretch so that the block backs up.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (out_fire)
            begin
                rx_wait = draw_wait(rx_quiet);
                if ($urandom_range(0, 49) == 0)
                    rx_quiet = !rx_quiet;
                if (results_seen == 150 || results_seen == 1200)
                    rx_wait = LONG_HOLD;
            end
            if (rx_wait > 0)
            begin
                rx_wait--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        status_t got;
        status_t want;
        in_fire  = rst_n && in_valid && !in_stall;
        out_fire = rst_n && out_valid && !out_stall;
        if (out_fire)
        begin
            got = {field_enable, power_enable, mode, fault_cause, on_periods, off_periods};
            results_seen++;
            if (pending_status.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected transaction: field=%0d power=%0d mode=%0d cause=%0d",
                             got.field, got.power, got.mode, got.cause);
            end
            else
            begin
                want = pending_status.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"transaction %0d: expected field=%0d power=%0d mode=%0d ",
                                  "cause=%0d on=%0d off=%0d, got field=%0d power=%0d ",
                                  "mode=%0d cause=%0d on=%0d off=%0d"},
                                 results_seen, want.field, want.power, want.mode,
                                 want.cause, want.on_cnt, want.off_cnt, got.field,
                                 got.power, got.mode, got.cause, got.on_cnt, got.off_cnt);
                end
            end
        end
        if (in_fire)
            pending_status.push_back(regulate_step({action, bus_volts_mv, bus_amps_ma,
                                                    avg_amps_ma, die_temp_c}));
        if (in_fire || out_fire)
            stuck = 0;
        else
            stuck++;
        if (stuck >= STUCK_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        sample_q.push_back(pack_item(frff_pkg::ACT_SAMPLE, 14000, 5000, 5000, 25));
        sample_q.push_back(pack_item(frff_pkg::ACT_SAMPLE, 14401, 5000, 5000, 25));
        sample_q.push_back(pack_item(frff_pkg::ACT_SAMPLE, 12000, 10001, 5000, 25));
        sample_q.push_back(pack_item(frff_pkg::ACT_SAMPLE, 14400, 10000, 10000, 125));
        sample_q.push_back(pack_item(frff_pkg::action_t'(5)));
        sample_q.push_back(pack_item(frff_pkg::action_t'(7)));
        sample_q.push_back(pack_item(frff_pkg::ACT_START));
        sample_q.push_back(pack_item(frff_pkg::ACT_STOP));
        sample_q.push_back(pack_item(frff_pkg::ACT_SAMPLE, 14000, 5000, 5000, 25));
        sample_q.push_back(pack_item(frff_pkg::ACT_SLEEP));
        sample_q.push_back(pack_item(frff_pkg::ACT_WAKE));
        sample_q.push_back(pack_item(frff_pkg::ACT_SAMPLE, 1439, 0, 11001, 0));
        sample_q.push_back(pack_item(frff_pkg::ACT_WAKE));
        sample_q.push_back(pack_item(frff_pkg::ACT_SLEEP));
        sample_q.push_back(pack_item(frff_pkg::ACT_START));
        sample_q.push_back(pack_item(frff_pkg::ACT_WAKE));
        sample_q.push_back(pack_item(frff_pkg::ACT_SAMPLE, 15841, 0, 999, 0));
        sample_q.push_back(pack_item(frff_pkg::ACT_SLEEP));
        sample_q.push_back(pack_item(frff_pkg::ACT_WAKE));
        sample_q.push_back(pack_item(frff_pkg::ACT_SAMPLE, 0, 0, 0, -256));
        sample_q.push_back(pack_item(frff_pkg::ACT_SLEEP));
        sample_q.push_back(pack_item(frff_pkg::ACT_WAKE));
        sample_q.push_back(pack_item(frff_pkg::ACT_STOP));
        sample_q.push_back(pack_item(frff_pkg::ACT_START));
        sample_q.push_back(pack_item(frff_pkg::ACT_SAMPLE, 100, 100, 100, 126));
        sample_q.push_back(pack_item(frff_pkg::ACT_SLEEP));
        sample_q.push_back(pack_item(frff_pkg::ACT_WAKE));
        sample_q.push_back(pack_item(frff_pkg::ACT_SAMPLE, 65535, 65535, 65535, 255));
        run_phase(PHASE_ITEMS);

        set_limit(frff_pkg::REG_VOLT_LIMIT, 32'd14400);
        set_limit(frff_pkg::REG_CURR_LIMIT, 32'd10000);
        set_limit(frff_pkg::REG_POWER_LIMIT, 32'd1000000);
        run_phase(PHASE_ITEMS);

        set_limit(frff_pkg::REG_VOLT_LIMIT, 32'd0);
        set_limit(frff_pkg::REG_CURR_LIMIT, 32'd0);
        set_limit(frff_pkg::REG_POWER_LIMIT, 32'd0);
        run_phase(PHASE_ITEMS);

        set_limit(frff_pkg::REG_VOLT_LIMIT, 32'd65535);
        set_limit(frff_pkg::REG_CURR_LIMIT, 32'd65535);
        set_limit(frff_pkg::REG_POWER_LIMIT, 32'hFFFF_FFFF);
        run_phase(PHASE_ITEMS);

        set_limit(frff_pkg::REG_VOLT_LIMIT, $urandom);
        set_limit(frff_pkg::REG_CURR_LIMIT, $urandom);
        set_limit(frff_pkg::REG_POWER_LIMIT, $urandom);
        set_limit(REG_UNUSED, $urandom);
        run_phase(PHASE_ITEMS);

        set_limit(frff_pkg::REG_VOLT_LIMIT, 32'd13800);
        set_limit(frff_pkg::REG_CURR_LIMIT, 32'd2000);
        set_limit(frff_pkg::REG_POWER_LIMIT, 32'd20000000);
        run_phase(PHASE_ITEMS);

        repeat (4) @(posedge clk);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
